// ===== src/mrc_pkg.sv =====
`default_nettype none

package mrc_pkg;

  // alpha format: unsigned fixed point, one unit is 1 << ALPHA_FRAC_BITS
  localparam int unsigned ALPHA_FRAC_BITS = 12;
  localparam int unsigned ALPHA_W         = ALPHA_FRAC_BITS + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1 << ALPHA_FRAC_BITS);
  localparam logic [ALPHA_W-1:0] ALPHA_HALF = ALPHA_W'(1 << (ALPHA_FRAC_BITS - 1));

  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned TENTHS_W = 4;
  localparam int unsigned FRAME_W  = 21;

  localparam int unsigned MAX_PIXELS_DEF = 1048576;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = FRAME_W;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_ENABLE        = CFG_INDEX_W'(0);
  localparam cfg_index_t REG_SHOW_MATTE    = CFG_INDEX_W'(1);
  localparam cfg_index_t REG_CUTOFF_TENTHS = CFG_INDEX_W'(2);
  localparam cfg_index_t REG_EMA_TENTHS    = CFG_INDEX_W'(3);
  localparam cfg_index_t REG_FRAME_PIXELS  = CFG_INDEX_W'(4);

  localparam logic                RST_ENABLE       = 1'b1;
  localparam logic                RST_SHOW_MATTE   = 1'b0;
  localparam logic [TENTHS_W-1:0] RST_TENTHS       = '0;
  localparam logic [FRAME_W-1:0]  RST_FRAME_PIXELS = FRAME_W'(921600);

  typedef struct packed {
    logic [ALPHA_W-1:0]  matte_alpha;
    logic [COLOUR_W-1:0] fg_red;
    logic [COLOUR_W-1:0] fg_green;
    logic [COLOUR_W-1:0] fg_blue;
    logic [COLOUR_W-1:0] bg_red;
    logic [COLOUR_W-1:0] bg_green;
    logic [COLOUR_W-1:0] bg_blue;
    logic                frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] out_red;
    logic [COLOUR_W-1:0] out_green;
    logic [COLOUR_W-1:0] out_blue;
  } pix_out_t;

  // pixel as it travels down the alpha pipeline
  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [COLOUR_W-1:0] fg_red;
    logic [COLOUR_W-1:0] fg_green;
    logic [COLOUR_W-1:0] fg_blue;
    logic [COLOUR_W-1:0] bg_red;
    logic [COLOUR_W-1:0] bg_green;
    logic [COLOUR_W-1:0] bg_blue;
    logic                en;
    logic                show;
  } item_t;

  // history access for one pixel: wr writes back, rmw also smooths against the old entry
  typedef struct packed {
    logic rmw;
    logic wr;
  } hist_op_t;

  function automatic int unsigned addr_bits(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/mrc_ram.sv =====
`default_nettype none

module mrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [mrc_pkg::addr_bits(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [mrc_pkg::addr_bits(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a read of the entry being written returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/mrc_ctrl.sv =====
`default_nettype none

module mrc_ctrl #(
  parameter int unsigned MAX_PIXELS = mrc_pkg::MAX_PIXELS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      advance,
  input  logic                                      frame_start,
  input  logic                                      enable,
  input  logic                                      ema_on,
  input  logic                                      frame_wr,
  input  logic [mrc_pkg::FRAME_W-1:0]               frame_pixels,
  output logic [mrc_pkg::addr_bits(MAX_PIXELS)-1:0] addr,
  output mrc_pkg::hist_op_t                         op
);

  import mrc_pkg::*;

  localparam int unsigned AW = addr_bits(MAX_PIXELS);

  logic [AW-1:0] pixel_address;
  logic          hist_valid;
  logic          hist_filling;

  logic [AW-1:0] pixel_address_next;
  logic          hist_valid_next;
  logic          hist_filling_next;
  logic [AW-1:0] len_m1;
  logic          restart;
  logic          last;
  logic          valid_cur;
  logic          filling_cur;

  always_comb begin
    if (frame_pixels == '0) begin
      len_m1 = '0;
    end else if (32'(frame_pixels) > 32'(MAX_PIXELS)) begin
      len_m1 = AW'(MAX_PIXELS - 1);
    end else begin
      len_m1 = AW'(frame_pixels - FRAME_W'(1));
    end
  end

  // early frame start means the frame size was wrong
  assign restart     = frame_start && (pixel_address != '0);
  assign addr        = frame_start ? '0 : pixel_address;
  assign last        = (addr == len_m1);
  assign valid_cur   = restart ? 1'b0 : hist_valid;
  assign filling_cur = restart ? 1'b0 : hist_filling;

  always_comb begin
    op                 = '0;
    hist_valid_next    = valid_cur;
    hist_filling_next  = filling_cur;
    pixel_address_next = last ? '0 : addr + AW'(1);
    if (enable) begin
      if (!ema_on) begin
        hist_valid_next   = 1'b0;
        hist_filling_next = 1'b0;
      end else if (valid_cur) begin
        op.rmw = 1'b1;
        op.wr  = 1'b1;
      end else begin
        op.wr = 1'b1;
        if (addr == '0) begin
          hist_filling_next = 1'b1;
        end
        // only a fill that began at the first pixel validates
        if (last && hist_filling_next) begin
          hist_valid_next   = 1'b1;
          hist_filling_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || frame_wr) begin
      pixel_address <= '0;
      hist_valid    <= 1'b0;
      hist_filling  <= 1'b0;
    end else if (advance) begin
      pixel_address <= pixel_address_next;
      hist_valid    <= hist_valid_next;
      hist_filling  <= hist_filling_next;
    end
  end

  a_fill_xor_valid: assert property (@(posedge clk) disable iff (rst)
    !(hist_valid && hist_filling))
    else $error("history valid while still filling");

  a_addr_in_frame: assert property (@(posedge clk) disable iff (rst)
    pixel_address <= len_m1)
    else $error("pixel address beyond frame");

endmodule

`default_nettype wire

// ===== src/mrc_refine.sv =====
`default_nettype none

module mrc_refine #(
  parameter int unsigned MAX_PIXELS = mrc_pkg::MAX_PIXELS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  mrc_pkg::item_t                            load_item,
  input  logic [mrc_pkg::addr_bits(MAX_PIXELS)-1:0] load_addr,
  input  mrc_pkg::hist_op_t                         load_op,
  output logic                                      ready,
  input  logic [mrc_pkg::addr_bits(MAX_PIXELS)-1:0] probe_addr,
  input  logic                                      probe_rmw,
  output logic                                      hazard,
  input  logic [mrc_pkg::TENTHS_W-1:0]              cutoff_tenths,
  input  logic [mrc_pkg::TENTHS_W-1:0]              ema_tenths,
  input  logic [mrc_pkg::ALPHA_W-1:0]               hist_rdata,
  output logic                                      hist_we,
  output logic [mrc_pkg::addr_bits(MAX_PIXELS)-1:0] hist_waddr,
  output logic [mrc_pkg::ALPHA_W-1:0]               hist_wdata,
  output logic                                      out_valid,
  output mrc_pkg::item_t                            out_item,
  input  logic                                      out_ready
);

  import mrc_pkg::*;

  localparam int unsigned AW          = addr_bits(MAX_PIXELS);
  localparam int unsigned NUM_W       = ALPHA_W + 4;           // holds ten times one
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;
  localparam int unsigned QD_W        = Q_W + TENTHS_W;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned DIV10_W     = 16;
  localparam logic [DIV10_W-1:0] DIV10_MUL = DIV10_W'(52429);  // exact below 81920
  localparam int unsigned HP_W        = NUM_W + DIV10_W;
  localparam logic [TENTHS_W-1:0] TEN = TENTHS_W'(10);

  function automatic logic [TENTHS_W-1:0] tenths_clamp(logic [TENTHS_W-1:0] v);
    return (v > TEN) ? TEN : v;
  endfunction

  // floor(2^16 / d)
  function automatic logic [RECIP_W-1:0] recip_tenth(logic [TENTHS_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = RECIP_W'(65536);
      4'd2:    r = RECIP_W'(32768);
      4'd3:    r = RECIP_W'(21845);
      4'd4:    r = RECIP_W'(16384);
      4'd5:    r = RECIP_W'(13107);
      4'd6:    r = RECIP_W'(10922);
      4'd7:    r = RECIP_W'(9362);
      4'd8:    r = RECIP_W'(8192);
      4'd9:    r = RECIP_W'(7281);
      default: r = '0;
    endcase
    return r;
  endfunction

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  item_t         it1, it2, it3, it4, it5;
  logic [AW-1:0] addr1, addr2, addr3, addr4;
  hist_op_t      op1, op2, op3, op4;

  logic [ALPHA_W-1:0] hist2, hist3;
  logic [NUM_W-1:0]   x2;
  logic [PROD_W-1:0]  prod2;
  logic               pass2, zero2;
  logic [NUM_W-1:0]   sum4;

  // stage 1: cutoff numerator and reciprocal product
  logic [TENTHS_W-1:0] c1, d1;
  logic [NUM_W-1:0]    ten_a1, c_one1, x1;
  logic [PROD_W-1:0]   prod1;
  logic                pass1, zero1;

  always_comb begin
    c1     = tenths_clamp(cutoff_tenths);
    d1     = TEN - c1;
    ten_a1 = NUM_W'(it1.alpha) * NUM_W'(10);
    c_one1 = NUM_W'(c1) << ALPHA_FRAC_BITS;
    pass1  = (c1 == '0);
    zero1  = (ten_a1 <= c_one1);
    x1     = ten_a1 - c_one1 + NUM_W'(d1 >> 1);
    prod1  = PROD_W'(x1) * PROD_W'(recip_tenth(d1));
  end

  // stage 2: quotient correction and clamp
  logic [TENTHS_W-1:0] d2;
  logic [Q_W-1:0]      q0, q;
  logic [QD_W-1:0]     rem2;
  logic [ALPHA_W-1:0]  acut;
  item_t               it2_cut;

  always_comb begin
    d2   = TEN - tenths_clamp(cutoff_tenths);
    q0   = prod2[PROD_W-1:RECIP_SHIFT];
    rem2 = QD_W'(x2) - QD_W'(q0) * QD_W'(d2);
    q    = (rem2 >= QD_W'(d2)) ? q0 + Q_W'(1) : q0;
    if (pass2) begin
      acut = it2.alpha;
    end else if (zero2) begin
      acut = '0;
    end else if (q > Q_W'(ALPHA_ONE)) begin
      acut = ALPHA_ONE;
    end else begin
      acut = q[ALPHA_W-1:0];
    end
    it2_cut       = it2;
    it2_cut.alpha = acut;
  end

  // stage 3: weighted sum of history and new alpha
  logic [TENTHS_W-1:0] e3;
  logic [NUM_W-1:0]    sum3;

  always_comb begin
    e3   = tenths_clamp(ema_tenths);
    sum3 = NUM_W'(hist3) * NUM_W'(e3) + NUM_W'(it3.alpha) * NUM_W'(TEN - e3)
           + NUM_W'(5);
  end

  // stage 4: divide by ten, write back
  logic [HP_W-1:0]    hprod4;
  logic [ALPHA_W-1:0] hnew4;
  item_t              it4_fin;

  always_comb begin
    hprod4 = HP_W'(sum4) * HP_W'(DIV10_MUL);
    if (hprod4[HP_W-1:DIV10_SHIFT] > (HP_W - DIV10_SHIFT)'(ALPHA_ONE)) begin
      hnew4 = ALPHA_ONE;
    end else begin
      hnew4 = hprod4[DIV10_SHIFT+ALPHA_W-1:DIV10_SHIFT];
    end
    it4_fin = it4;
    if (op4.rmw) begin
      it4_fin.alpha = hnew4;
    end
  end

  assign r5    = !v5 || out_ready;
  assign r4    = !v4 || r5;
  assign r3    = !v3 || r4;
  assign r2    = !v2 || r3;
  assign r1    = !v1 || r2;
  assign ready = r1;

  // any older pixel of the same address that has not yet written its entry blocks a smoothing read
  assign hazard = probe_rmw && (
      (v1 && op1.wr && (addr1 == probe_addr)) ||
      (v2 && op2.wr && (addr2 == probe_addr)) ||
      (v3 && op3.wr && (addr3 == probe_addr)) ||
      (v4 && op4.wr && (addr4 == probe_addr)));

  assign hist_we    = v4 && r5 && op4.wr;
  assign hist_waddr = addr4;
  assign hist_wdata = it4_fin.alpha;

  assign out_valid = v5;
  assign out_item  = it5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= load;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && load) begin
      it1   <= load_item;
      addr1 <= load_addr;
      op1   <= load_op;
    end
    // memory word of the stage 1 pixel is held until the next load
    if (r2 && v1) begin
      it2   <= it1;
      addr2 <= addr1;
      op2   <= op1;
      hist2 <= hist_rdata;
      x2    <= x1;
      prod2 <= prod1;
      pass2 <= pass1;
      zero2 <= zero1;
    end
    if (r3 && v2) begin
      it3   <= it2_cut;
      addr3 <= addr2;
      op3   <= op2;
      hist3 <= hist2;
    end
    if (r4 && v3) begin
      it4   <= it3;
      addr4 <= addr3;
      op4   <= op3;
      sum4  <= sum3;
    end
    if (r5 && v4) begin
      it5 <= it4_fin;
    end
  end

  a_wdata_range: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (hist_wdata <= ALPHA_ONE))
    else $error("history write above one");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.alpha <= ALPHA_ONE))
    else $error("refined alpha above one");

endmodule

`default_nettype wire

// ===== src/mrc_blend.sv =====
`default_nettype none

module mrc_blend (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mrc_pkg::item_t    in_item,
  output logic              ready,
  output logic              res_valid,
  input  logic              res_stall,
  output mrc_pkg::pix_out_t res_word
);

  import mrc_pkg::*;

  localparam int unsigned SUM_W = COLOUR_W + ALPHA_W;

  function automatic logic [COLOUR_W-1:0] sat_round(logic [SUM_W-1:0] v);
    logic [SUM_W-ALPHA_FRAC_BITS-1:0] s;
    s = v[SUM_W-1:ALPHA_FRAC_BITS];
    return (s > (SUM_W - ALPHA_FRAC_BITS)'(255)) ? COLOUR_W'(255) : s[COLOUR_W-1:0];
  endfunction

  function automatic logic [COLOUR_W-1:0] blend_ch(logic [COLOUR_W-1:0] f,
                                                   logic [COLOUR_W-1:0] b,
                                                   logic [ALPHA_W-1:0]  a);
    logic [SUM_W-1:0] v;
    v = SUM_W'(f) * SUM_W'(a) + SUM_W'(b) * SUM_W'(ALPHA_ONE - a) + SUM_W'(ALPHA_HALF);
    return sat_round(v);
  endfunction

  pix_out_t         res_next;
  logic [SUM_W-1:0] gray_sum;
  logic [COLOUR_W-1:0] gray;

  always_comb begin
    gray_sum = SUM_W'(in_item.alpha) * SUM_W'(255) + SUM_W'(ALPHA_HALF);
    gray     = sat_round(gray_sum);
    if (!in_item.en) begin
      res_next.out_red   = in_item.fg_red;
      res_next.out_green = in_item.fg_green;
      res_next.out_blue  = in_item.fg_blue;
    end else if (in_item.show) begin
      res_next.out_red   = gray;
      res_next.out_green = gray;
      res_next.out_blue  = gray;
    end else begin
      res_next.out_red   = blend_ch(in_item.fg_red, in_item.bg_red, in_item.alpha);
      res_next.out_green = blend_ch(in_item.fg_green, in_item.bg_green, in_item.alpha);
      res_next.out_blue  = blend_ch(in_item.fg_blue, in_item.bg_blue, in_item.alpha);
    end
  end

  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      res_word <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/matte_refine_and_composite.sv =====
`default_nettype none

// matte refinement and alpha compositing, one pixel per clock while not stalled
//
// pixel channel: pixel_valid / pixel_stall / pixel_word, a word is taken at an edge
//   with valid high and stall low. each word carries a raw alpha (1/4096 units),
//   a foreground and a background pixel and a frame start flag
// result channel: comp_valid / comp_stall / comp_word, one composited pixel per
//   input word, in order, through the refine stages and the blend output register
// throughput: one pixel per cycle while neither stalled nor blocked. the history
//   read-modify-write loop through the single-port-write history memory sets the
//   limit: with smoothing on, a pixel waits until no earlier pixel of the same
//   address is still in the 4 stages up to write-back, so frames of under five pixels slow
// stall: a stalled result is held in the output register; the pipeline keeps
//   taking pixels until all five internal stages are full, then raises pixel_stall
// config: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready; the user must write
//   while no pixel is in flight, not enforced. writing the frame size drops the history
// reset: synchronous, clears the pipeline, pixel address and history flags and
//   loads register defaults; the history memory itself needs no clearing
module matte_refine_and_composite #(
  parameter int unsigned MAX_PIXELS = mrc_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  mrc_pkg::pix_in_t               pixel_word,
  output logic                           comp_valid,
  input  logic                           comp_stall,
  output mrc_pkg::pix_out_t              comp_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mrc_pkg::*;

  localparam int unsigned AW = addr_bits(MAX_PIXELS);

  // configuration registers
  logic                enable;
  logic                show_matte;
  logic [TENTHS_W-1:0] cutoff_tenths;
  logic [TENTHS_W-1:0] ema_tenths;
  logic [FRAME_W-1:0]  frame_pixels;
  logic                frame_wr;

  assign cfg_ready = 1'b1;
  assign frame_wr  = cfg_valid && (cfg_index == REG_FRAME_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= RST_ENABLE;
      show_matte    <= RST_SHOW_MATTE;
      cutoff_tenths <= RST_TENTHS;
      ema_tenths    <= RST_TENTHS;
      frame_pixels  <= RST_FRAME_PIXELS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:        enable        <= cfg_data[0];
        REG_SHOW_MATTE:    show_matte    <= cfg_data[0];
        REG_CUTOFF_TENTHS: cutoff_tenths <= cfg_data[TENTHS_W-1:0];
        REG_EMA_TENTHS:    ema_tenths    <= cfg_data[TENTHS_W-1:0];
        REG_FRAME_PIXELS:  frame_pixels  <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  logic          accept;
  logic          pipe_ready;
  logic          hazard;
  logic [AW-1:0] cur_addr;
  hist_op_t      cur_op;
  item_t         load_item;

  assign pixel_stall = !pipe_ready || hazard;
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    load_item.alpha    = (pixel_word.matte_alpha > ALPHA_ONE) ? ALPHA_ONE
                                                              : pixel_word.matte_alpha;
    load_item.fg_red   = pixel_word.fg_red;
    load_item.fg_green = pixel_word.fg_green;
    load_item.fg_blue  = pixel_word.fg_blue;
    load_item.bg_red   = pixel_word.bg_red;
    load_item.bg_green = pixel_word.bg_green;
    load_item.bg_blue  = pixel_word.bg_blue;
    load_item.en       = enable;
    load_item.show     = show_matte;
  end

  // pixel address and history validity, stepped once per accepted word
  mrc_ctrl #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_start  (pixel_word.frame_start),
    .enable       (enable),
    .ema_on       (ema_tenths != '0),
    .frame_wr     (frame_wr),
    .frame_pixels (frame_pixels),
    .addr         (cur_addr),
    .op           (cur_op)
  );

  // history store, read as the word is taken, written back at stage 4
  logic               hist_we;
  logic [AW-1:0]      hist_waddr;
  logic [ALPHA_W-1:0] hist_wdata;
  logic [ALPHA_W-1:0] hist_rdata;

  mrc_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (MAX_PIXELS)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (accept),
    .raddr (cur_addr),
    .rdata (hist_rdata)
  );

  // cutoff, rescale and temporal smoothing
  logic  refined_valid;
  item_t refined_item;
  logic  blend_ready;

  mrc_refine #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_refine (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .load_item     (load_item),
    .load_addr     (cur_addr),
    .load_op       (cur_op),
    .ready         (pipe_ready),
    .probe_addr    (cur_addr),
    .probe_rmw     (cur_op.rmw),
    .hazard        (hazard),
    .cutoff_tenths (cutoff_tenths),
    .ema_tenths    (ema_tenths),
    .hist_rdata    (hist_rdata),
    .hist_we       (hist_we),
    .hist_waddr    (hist_waddr),
    .hist_wdata    (hist_wdata),
    .out_valid     (refined_valid),
    .out_item      (refined_item),
    .out_ready     (blend_ready)
  );

  // blend, gray view or pass-through into the output register
  mrc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (refined_valid),
    .in_item   (refined_item),
    .ready     (blend_ready),
    .res_valid (comp_valid),
    .res_stall (comp_stall),
    .res_word  (comp_word)
  );

endmodule

`default_nettype wire
